// ===== design/rsce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsce_pkg
// Shared types, encodings and bus widths for the SYSTEM instruction execute
// block.
// ----------------------------------------------------------------------------
package rsce_pkg;

   // stream bus widths, whole bytes
   localparam int unsigned REQ_DATA_W = 136;
   localparam int unsigned RSP_DATA_W = 160;

   // instruction fields
   localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

   // funct3 codes of the SYSTEM opcode
   localparam logic [2:0] F3_PRIV     = 3'd0;
   localparam logic [2:0] F3_RESERVED = 3'd4;

   // low two bits of funct3 for the csr forms
   localparam logic [1:0] CSR_OP_WRITE = 2'b01;
   localparam logic [1:0] CSR_OP_SET   = 2'b10;

   // privileged group encodings
   localparam logic [11:0] IMM_ECALL   = 12'b000000000000;
   localparam logic [11:0] IMM_EBREAK  = 12'b000000000001;
   localparam logic [6:0]  F7_SRET_WFI = 7'b0001000;
   localparam logic [6:0]  F7_MRET     = 7'b0011000;
   localparam logic [6:0]  F7_SFENCE   = 7'b0001001;
   localparam logic [4:0]  RS2_XRET    = 5'b00010;
   localparam logic [4:0]  RS2_WFI     = 5'b00101;

   // result event codes
   localparam logic [2:0] EV_CSR   = 3'd0;
   localparam logic [2:0] EV_EXC   = 3'd1;
   localparam logic [2:0] EV_SRET  = 3'd2;
   localparam logic [2:0] EV_MRET  = 3'd3;
   localparam logic [2:0] EV_WFI   = 3'd4;
   localparam logic [2:0] EV_FLUSH = 3'd5;
   localparam logic [2:0] EV_UNSUP = 3'd6;

   // exception causes
   localparam logic [1:0] CAUSE_ECALL = 2'd0;
   localparam logic [1:0] CAUSE_BRK   = 2'd1;
   localparam logic [1:0] CAUSE_ILL   = 2'd2;

   // one request item
   typedef struct packed {
      logic [31:0] instruction;
      logic [31:0] inst_pc;
      logic [1:0]  priv_level;
      logic [31:0] rs1_value;
      logic [31:0] csr_read_value;
      logic        csr_read_ok;
      logic        csr_write_ok;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic [2:0]  event_res;
      logic [1:0]  cause;
      logic [31:0] target_pc;
      logic [31:0] trap_value;
      logic [1:0]  priv_out;
      logic [11:0] csr_addr;
      logic        csr_read_enable;
      logic        csr_write_enable;
      logic [31:0] csr_write_value;
      logic [4:0]  rd_index;
      logic        rd_write_enable;
      logic [31:0] rd_value;
   } rsp_item_type;

endpackage : rsce_pkg
`default_nettype wire

// ===== design/riscv_system_csr_execute.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// riscv_system_csr_execute
// Execute step for RV32 SYSTEM instructions: privileged events and Zicsr
// read-modify-write with rd writeback.
// ----------------------------------------------------------------------------
// Takes one request per clock while the result side keeps up, and returns
// exactly one result per request. A request is captured in the input
// register, which feeds the decode and csr logic; that logic loads the result
// register, which drives the result channel. Throughput is one request per
// cycle while rsp_tready holds; the result register and the input register
// each hold one item, so a request is still taken into an empty input register
// while a finished result waits on rsp_tready. ECALL and EBREAK
// trap, SRET, MRET, WFI and SFENCE.VMA become events, a refused csr access
// traps as an illegal instruction with the instruction as tval, and encodings
// outside this set come back as unsupported with all other fields zero.
module riscv_system_csr_execute (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // instruction, inst_pc, priv_level, rs1_value, csr_read_value,
   // csr_read_ok, csr_write_ok
   input  wire logic [rsce_pkg::REQ_DATA_W-1:0] req_tdata,
   // result channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // event_res, cause, target_pc, trap_value, priv_out, csr_addr,
   // csr_read_enable, csr_write_enable, csr_write_value, rd_index,
   // rd_write_enable, rd_value
   output logic [rsce_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // pipeline control
   logic                   s1_valid_ff, s1_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_load;
   logic                   s1_load;

   // payload registers
   rsce_pkg::req_item_type s1_item_ff, s1_item_in;
   rsce_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   // decode of the registered request
   logic [6:0]  opcode;
   logic [2:0]  funct3;
   logic [6:0]  funct7;
   logic [11:0] imm12;
   logic [4:0]  rs2_f;
   logic [4:0]  rs1_f;
   logic [4:0]  rd_f;
   logic [31:0] src_val;
   logic [31:0] old_val;
   logic [31:0] new_val;
   logic        is_write_form;
   logic        do_read;
   logic        do_write;
   logic        read_fault;
   logic        xret_base;

   // handshake: result register moves when empty or taken
   assign rsp_load    = !rsp_valid_ff || rsp_tready;
   assign s1_load     = !s1_valid_ff || rsp_load;
   assign req_tready  = s1_load;
   assign s1_valid_in = s1_load ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = rsp_load ? s1_valid_ff : rsp_valid_ff;

   // unpack the request bus
   always_comb begin
      s1_item_in.instruction    = req_tdata[31:0];
      s1_item_in.inst_pc        = req_tdata[63:32];
      s1_item_in.priv_level     = req_tdata[65:64];
      s1_item_in.rs1_value      = req_tdata[97:66];
      s1_item_in.csr_read_value = req_tdata[129:98];
      s1_item_in.csr_read_ok    = req_tdata[130];
      s1_item_in.csr_write_ok   = req_tdata[131];
   end

   // instruction fields
   assign opcode = s1_item_ff.instruction[6:0];
   assign funct3 = s1_item_ff.instruction[14:12];
   assign funct7 = s1_item_ff.instruction[31:25];
   assign imm12  = s1_item_ff.instruction[31:20];
   assign rs2_f  = s1_item_ff.instruction[24:20];
   assign rs1_f  = s1_item_ff.instruction[19:15];
   assign rd_f   = s1_item_ff.instruction[11:7];

   // csr operand and read-modify-write value
   assign src_val       = funct3[2] ? {27'd0, rs1_f} : s1_item_ff.rs1_value;
   assign is_write_form = (funct3[1:0] == rsce_pkg::CSR_OP_WRITE);
   assign do_read       = is_write_form ? (rd_f != 5'd0) : 1'b1;
   assign read_fault    = do_read && !s1_item_ff.csr_read_ok;
   assign old_val       = do_read ? s1_item_ff.csr_read_value : 32'd0;
   assign do_write      = is_write_form || (src_val != 32'd0);
   assign xret_base     = (rs1_f == 5'd0) && (rd_f == 5'd0);

   always_comb begin
      if (is_write_form) begin
         new_val = src_val;
      end else if (funct3[1:0] == rsce_pkg::CSR_OP_SET) begin
         new_val = old_val | src_val;
      end else begin
         new_val = old_val & ~src_val;
      end
   end

   // result of one instruction
   always_comb begin
      rsp_item_in = '0;
      if (opcode != rsce_pkg::OPC_SYSTEM || funct3 == rsce_pkg::F3_RESERVED) begin
         rsp_item_in.event_res = rsce_pkg::EV_UNSUP;
      end else if (funct3 == rsce_pkg::F3_PRIV) begin
         // privileged group, no privilege check here
         if (imm12 == rsce_pkg::IMM_ECALL && xret_base) begin
            rsp_item_in.event_res = rsce_pkg::EV_EXC;
            rsp_item_in.cause     = rsce_pkg::CAUSE_ECALL;
            rsp_item_in.target_pc = s1_item_ff.inst_pc;
            rsp_item_in.priv_out  = s1_item_ff.priv_level;
         end else if (imm12 == rsce_pkg::IMM_EBREAK && xret_base) begin
            rsp_item_in.event_res  = rsce_pkg::EV_EXC;
            rsp_item_in.cause      = rsce_pkg::CAUSE_BRK;
            rsp_item_in.target_pc  = s1_item_ff.inst_pc;
            rsp_item_in.trap_value = s1_item_ff.inst_pc;
            rsp_item_in.priv_out   = s1_item_ff.priv_level;
         end else if (funct7 == rsce_pkg::F7_SRET_WFI && rs2_f == rsce_pkg::RS2_XRET
                      && xret_base) begin
            rsp_item_in.event_res = rsce_pkg::EV_SRET;
            rsp_item_in.target_pc = s1_item_ff.inst_pc;
            rsp_item_in.priv_out  = s1_item_ff.priv_level;
         end else if (funct7 == rsce_pkg::F7_MRET && rs2_f == rsce_pkg::RS2_XRET
                      && xret_base) begin
            rsp_item_in.event_res = rsce_pkg::EV_MRET;
            rsp_item_in.target_pc = s1_item_ff.inst_pc;
            rsp_item_in.priv_out  = s1_item_ff.priv_level;
         end else if (funct7 == rsce_pkg::F7_SRET_WFI && rs2_f == rsce_pkg::RS2_WFI
                      && xret_base) begin
            rsp_item_in.event_res = rsce_pkg::EV_WFI;
            rsp_item_in.target_pc = s1_item_ff.inst_pc + 32'd4;
         end else if (funct7 == rsce_pkg::F7_SFENCE && rd_f == 5'd0) begin
            rsp_item_in.event_res = rsce_pkg::EV_FLUSH;
         end else begin
            rsp_item_in.event_res = rsce_pkg::EV_UNSUP;
         end
      end else begin
         // csr read-modify-write
         rsp_item_in.csr_addr        = imm12;
         rsp_item_in.rd_index        = rd_f;
         rsp_item_in.csr_read_enable = do_read;
         if (read_fault) begin
            rsp_item_in.event_res  = rsce_pkg::EV_EXC;
            rsp_item_in.cause      = rsce_pkg::CAUSE_ILL;
            rsp_item_in.target_pc  = s1_item_ff.inst_pc;
            rsp_item_in.trap_value = s1_item_ff.instruction;
            rsp_item_in.priv_out   = s1_item_ff.priv_level;
         end else begin
            rsp_item_in.csr_write_enable = do_write;
            rsp_item_in.csr_write_value  = do_write ? new_val : 32'd0;
            if (do_write && !s1_item_ff.csr_write_ok) begin
               rsp_item_in.event_res  = rsce_pkg::EV_EXC;
               rsp_item_in.cause      = rsce_pkg::CAUSE_ILL;
               rsp_item_in.target_pc  = s1_item_ff.inst_pc;
               rsp_item_in.trap_value = s1_item_ff.instruction;
               rsp_item_in.priv_out   = s1_item_ff.priv_level;
            end else begin
               rsp_item_in.event_res       = rsce_pkg::EV_CSR;
               rsp_item_in.rd_write_enable = (rd_f != 5'd0);
               rsp_item_in.rd_value        = (rd_f != 5'd0) ? old_val : 32'd0;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_item_ff <= s1_item_in;
      end
      if (rsp_load) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // pack the result bus
   assign rsp_tvalid = rsp_valid_ff;
   always_comb begin
      rsp_tdata          = '0;
      rsp_tdata[2:0]     = rsp_item_ff.event_res;
      rsp_tdata[4:3]     = rsp_item_ff.cause;
      rsp_tdata[36:5]    = rsp_item_ff.target_pc;
      rsp_tdata[68:37]   = rsp_item_ff.trap_value;
      rsp_tdata[70:69]   = rsp_item_ff.priv_out;
      rsp_tdata[82:71]   = rsp_item_ff.csr_addr;
      rsp_tdata[83]      = rsp_item_ff.csr_read_enable;
      rsp_tdata[84]      = rsp_item_ff.csr_write_enable;
      rsp_tdata[116:85]  = rsp_item_ff.csr_write_value;
      rsp_tdata[121:117] = rsp_item_ff.rd_index;
      rsp_tdata[122]     = rsp_item_ff.rd_write_enable;
      rsp_tdata[154:123] = rsp_item_ff.rd_value;
   end

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid_ff && !s1_valid_ff))
      else $error("pipeline not empty after reset");

   // unsupported results carry no other information
   a_unsup_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.event_res == rsce_pkg::EV_UNSUP) |->
      (rsp_item_ff.target_pc == 32'd0 && !rsp_item_ff.csr_read_enable
       && !rsp_item_ff.csr_write_enable && !rsp_item_ff.rd_write_enable
       && rsp_item_ff.csr_addr == 12'd0))
      else $error("unsupported result with live fields");

   // rd writeback only for a completed csr op
   a_rd_csr_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.rd_write_enable) |->
      (rsp_item_ff.event_res == rsce_pkg::EV_CSR && rsp_item_ff.rd_index != 5'd0))
      else $error("rd writeback outside csr completion");

   // a nonzero cause belongs to an exception
   a_cause_exc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.cause != rsce_pkg::CAUSE_ECALL) |->
      (rsp_item_ff.event_res == rsce_pkg::EV_EXC))
      else $error("cause set without exception");

   // a write value only comes with a write request
   a_wv_we: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.csr_write_enable) |->
      (rsp_item_ff.csr_write_value == 32'd0))
      else $error("csr write value without write request");

endmodule : riscv_system_csr_execute
`default_nettype wire
